// File: rtl/spca_pkg.sv
package spca_pkg;

    localparam int MAX_CHUNKS      = 64;
    localparam int MAX_CHUNK_SHIFT = 8;
    localparam int PIXEL_BITS      = 30;

    localparam int SLOT_W  = $clog2(MAX_CHUNKS);
    localparam int COUNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int SHIFT_W = 4;
    localparam int OFF_W   = MAX_CHUNK_SHIFT;
    localparam int ROW_W   = 1 << MAX_CHUNK_SHIFT;
    localparam int ADDR_W  = SLOT_W + MAX_CHUNK_SHIFT;
    localparam int DEPTH   = MAX_CHUNKS << MAX_CHUNK_SHIFT;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MEM,
        S_WB
    } t_state;

    typedef struct packed {
        logic load;
        logic look;
        logic mem;
        logic wb;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

endpackage

// File: rtl/spca_if.sv
interface spca_in_if;
    import spca_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [PIXEL_BITS-1:0]      pixel;
    logic signed [VALUE_W-1:0]  increment;

    modport source (output valid, output cmd, output pixel, output increment, input ready);
    modport sink   (input valid, input cmd, input pixel, input increment, output ready);
endinterface

interface spca_out_if;
    import spca_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic                       status;
    logic [COUNT_W-1:0]         active_chunks;
    logic                       new_chunk;

    modport source (output valid, output value, output status, output active_chunks,
                    output new_chunk, input ready);
    modport sink   (input valid, input value, input status, input active_chunks,
                    input new_chunk, output ready);
endinterface

interface spca_cfg_if;
    import spca_pkg::*;
    logic               valid;
    logic               ready;
    logic [SHIFT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/spca_ctrl.sv
module spca_ctrl
    import spca_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_MEM;
            end
            S_MEM: begin
                o_cmd.mem = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                // hold until the output register can take the item
                if (i_sts.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/spca_datapath.sv
module spca_datapath
    import spca_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl_cmd                 i_cmd,
    output t_ctrl_sts                 o_sts,
    input  logic                      i_cfg_we,
    input  logic [SHIFT_W-1:0]        i_cfg_data,
    input  logic [CMD_W-1:0]          i_cmd_code,
    input  logic [PIXEL_BITS-1:0]     i_pixel,
    input  logic signed [VALUE_W-1:0] i_increment,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_status,
    output logic [COUNT_W-1:0]        o_active_chunks,
    output logic                      o_new_chunk
);

    logic [SHIFT_W-1:0]        r_shift;
    logic [SHIFT_W-1:0]        w_eff_sh;

    logic [CMD_W-1:0]          r_cmd;
    logic [PIXEL_BITS-1:0]     r_pix;
    logic signed [VALUE_W-1:0] r_inc;
    logic [SHIFT_W-1:0]        r_sh;

    logic [PIXEL_BITS-1:0]     r_tags [MAX_CHUNKS];
    logic [COUNT_W-1:0]        r_active;
    logic [MAX_CHUNKS-1:0]     r_row_valid;

    logic [PIXEL_BITS-1:0]     w_tag;
    logic                      w_hit;
    logic [SLOT_W-1:0]         w_slot;
    logic [OFF_W-1:0]          w_hi_mask;

    logic                      r_hit;
    logic [SLOT_W-1:0]         r_slot;
    logic [PIXEL_BITS-1:0]     r_tag;
    logic [OFF_W-1:0]          r_off;

    logic                      w_full;
    logic                      w_alloc;
    logic [SLOT_W-1:0]         w_slot_eff;
    logic [ADDR_W-1:0]         w_addr;
    logic                      w_rd_en;

    logic                      r_full;
    logic                      r_alloc;
    logic [ADDR_W-1:0]         r_addr;

    logic [VALUE_W-1:0]        r_cnt_mem [DEPTH];
    logic [ROW_W-1:0]          r_wr_mem  [MAX_CHUNKS];
    logic [VALUE_W-1:0]        r_cnt_q;
    logic [ROW_W-1:0]          r_wr_q;
    logic                      r_rv;

    logic [OFF_W-1:0]          w_bit;
    logic [SLOT_W-1:0]         w_row;
    logic [ROW_W-1:0]          w_range;
    logic [ROW_W-1:0]          w_new_row;
    logic                      w_written;
    logic signed [VALUE_W-1:0] w_old;
    logic signed [VALUE_W:0]   w_sum;
    logic signed [VALUE_W-1:0] w_sat;
    logic                      w_add_wr;

    logic signed [VALUE_W-1:0] w_res_value;
    logic                      w_res_status;
    logic [COUNT_W-1:0]        w_res_active;
    logic                      w_res_new;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_status;
    logic [COUNT_W-1:0]        r_out_active;
    logic                      r_out_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_W'(4);
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_data;
        end
    end

    assign w_eff_sh = (r_shift > SHIFT_W'(MAX_CHUNK_SHIFT)) ? SHIFT_W'(MAX_CHUNK_SHIFT)
                                                             : r_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_code;
            r_pix <= i_pixel;
            r_inc <= i_increment;
            r_sh  <= w_eff_sh;
        end
    end

    // tag lookup: lowest matching active slot wins
    assign w_tag     = r_pix >> r_sh;
    assign w_hi_mask = OFF_W'({OFF_W{1'b1}} << r_sh);

    always_comb begin
        w_hit  = 1'b0;
        w_slot = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < r_active) && (r_tags[i] == w_tag)) begin
                w_hit  = 1'b1;
                w_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit  <= w_hit;
            r_slot <= w_slot;
            r_tag  <= w_tag;
            r_off  <= r_pix[OFF_W-1:0] & ~w_hi_mask;
        end
    end

    assign w_full     = !r_hit && (r_active == COUNT_W'(MAX_CHUNKS));
    assign w_alloc    = (r_cmd == CMD_ADD) && !r_hit && !w_full;
    assign w_slot_eff = r_hit ? r_slot : r_active[SLOT_W-1:0];
    assign w_addr     = (ADDR_W'(w_slot_eff) << r_sh) | ADDR_W'(r_off);
    assign w_rd_en    = i_cmd.mem && (((r_cmd == CMD_ADD) && !w_full) ||
                                      ((r_cmd == CMD_READ) && r_hit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem) begin
            r_full  <= w_full;
            r_alloc <= w_alloc;
            r_addr  <= w_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem && w_alloc) begin
            r_tags[r_active[SLOT_W-1:0]] <= r_tag;
        end
    end

    // writeback
    assign w_bit   = r_addr[OFF_W-1:0];
    assign w_row   = r_addr[ADDR_W-1:OFF_W];

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            w_range[j] = ((OFF_W'(j) ^ w_bit) & w_hi_mask) == '0;
        end
    end

    assign w_written = r_rv && r_wr_q[w_bit] && !r_alloc;
    assign w_old     = w_written ? r_cnt_q : '0;
    assign w_sum     = {w_old[VALUE_W-1], w_old} + {r_inc[VALUE_W-1], r_inc};
    assign w_sat     = (w_sum[VALUE_W] != w_sum[VALUE_W-1])
                       ? (w_sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                         : {1'b0, {(VALUE_W-1){1'b1}}})
                       : w_sum[VALUE_W-1:0];
    assign w_new_row = ((r_rv ? r_wr_q : '0) & ~(r_alloc ? w_range : '0))
                       | (ROW_W'(1) << w_bit);
    assign w_add_wr  = i_cmd.wb && (r_cmd == CMD_ADD) && !r_full;

    always_ff @(posedge i_clk) begin
        if (w_add_wr) begin
            r_cnt_mem[r_addr] <= w_sat;
            r_wr_mem[w_row]   <= w_new_row;
        end
        if (w_rd_en) begin
            r_cnt_q <= r_cnt_mem[w_addr];
            r_wr_q  <= r_wr_mem[w_addr[ADDR_W-1:OFF_W]];
            r_rv    <= r_row_valid[w_addr[ADDR_W-1:OFF_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_row_valid <= '0;
        end else begin
            if (i_cmd.mem && w_alloc) begin
                r_active <= r_active + COUNT_W'(1);
            end
            if (w_add_wr) begin
                r_row_valid[w_row] <= 1'b1;
            end
            if (i_cmd.wb && (r_cmd == CMD_CLEAR)) begin
                r_active    <= '0;
                r_row_valid <= '0;
            end
        end
    end

    always_comb begin
        w_res_value  = '0;
        w_res_status = 1'b0;
        w_res_active = r_active;
        w_res_new    = 1'b0;
        case (r_cmd)
            CMD_ADD: begin
                if (r_full) begin
                    w_res_status = 1'b1;
                end else begin
                    w_res_value = w_sat;
                    w_res_new   = r_alloc;
                end
            end
            CMD_READ: begin
                if (r_hit && w_written) begin
                    w_res_value = r_cnt_q;
                end
            end
            CMD_CLEAR: begin
                w_res_active = '0;
            end
            default: begin
                w_res_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wb) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out_value  <= w_res_value;
            r_out_status <= w_res_status;
            r_out_active <= w_res_active;
            r_out_new    <= w_res_new;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_value         = r_out_value;
    assign o_status        = r_out_status;
    assign o_active_chunks = r_out_active;
    assign o_new_chunk     = r_out_new;

endmodule

// File: rtl/sparse_chunked_pixel_accumulator.sv
// An item goes through LOOK (tag compare over the chunk table), MEM (count
// memory read) and WB (saturating add, read-modify-write of the entry, result
// registered to the output). A new item is taken only once the last is done.
// A result waiting on the output stalls only the next item's writeback.
// Reset: synchronous, active low; clears the chunk table, the row valid bits
// and the output register, and sets chunk_shift to 4. No clearing pass.
module sparse_chunked_pixel_accumulator
    import spca_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    spca_in_if.sink      i_in,
    spca_out_if.source   o_out,
    spca_cfg_if.sink     i_cfg
);

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    logic      w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    spca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_in_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    spca_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_cmd_code      (i_in.cmd),
        .i_pixel         (i_in.pixel),
        .i_increment     (i_in.increment),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_value         (o_out.value),
        .o_status        (o_out.status),
        .o_active_chunks (o_out.active_chunks),
        .o_new_chunk     (o_out.new_chunk)
    );

endmodule

// File: test/sparse_chunked_pixel_accumulator_tb.sv
module sparse_chunked_pixel_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spca_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 105;
    localparam int HOT_N       = 72;
    localparam int N_DIR       = 21;
    localparam int HOLD_CYCLES = 150;
    localparam logic [SHIFT_W-1:0] PHASE_SHIFT [N_PHASES] =
        '{4'd0, 4'd8, 4'd15, 4'd3, 4'd12, 4'd6};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      status;
        logic [COUNT_W-1:0]        active;
        logic                      fresh;
    } t_pix_result;

    typedef struct {
        logic [CMD_W-1:0]      cmd;
        logic [PIXEL_BITS-1:0] pixel;
        logic [VALUE_W-1:0]    inc;
        bit                    typed;
        t_pix_result           res;
    } t_dir_row;

    logic clk;
    logic rst_n;

    spca_in_if  in_ch();
    spca_out_if out_ch();
    spca_cfg_if cfg_ch();

    sparse_chunked_pixel_accumulator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // pixel map mirror
    logic [SHIFT_W-1:0]        shift_now;
    logic [PIXEL_BITS-1:0]     chunk_tag [MAX_CHUNKS];
    int                        live_chunks;
    logic signed [VALUE_W-1:0] count_mem [DEPTH];
    bit                        entry_set [DEPTH];

    t_pix_result           pixel_results_q[$];
    logic [PIXEL_BITS-1:0] recent_pix[$];
    logic [PIXEL_BITS-1:0] hot_pix [HOT_N];

    int snd_idle;
    int rcv_stall;
    int hold_left;
    int mismatches;
    int quiet_cycles;

    t_dir_row dir_tab [N_DIR] = '{
        '{CMD_READ,  30'h0000_0000, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 7'd0, 1'b0}},
        '{CMD_SPARE, 30'h0000_0005, 32'h0000_0007, 1'b1, '{32'sh0000_0000, 1'b0, 7'd0, 1'b0}},
        '{CMD_ADD,   30'h0000_0012, 32'h0001_0000, 1'b1, '{32'sh0001_0000, 1'b0, 7'd1, 1'b1}},
        '{CMD_ADD,   30'h0000_0013, 32'h7FFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 7'd1, 1'b0}},
        '{CMD_ADD,   30'h0000_0013, 32'h0000_0001, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 7'd1, 1'b0}},
        '{CMD_ADD,   30'h3FFF_FFFF, 32'h8000_0000, 1'b1, '{32'sh8000_0000, 1'b0, 7'd2, 1'b1}},
        '{CMD_ADD,   30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'sh8000_0000, 1'b0, 7'd2, 1'b0}},
        '{CMD_READ,  30'h0000_0012, 32'h0000_0000, 1'b1, '{32'sh0001_0000, 1'b0, 7'd2, 1'b0}},
        '{CMD_READ,  30'h0000_0014, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 7'd2, 1'b0}},
        '{CMD_READ,  30'h0000_0100, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 7'd2, 1'b0}},
        '{CMD_ADD,   30'h0000_0013, 32'h8000_0000, 1'b1, '{32'shFFFF_FFFF, 1'b0, 7'd2, 1'b0}},
        '{CMD_SPARE, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'sh0000_0000, 1'b0, 7'd2, 1'b0}},
        '{CMD_ADD,   30'h2AAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{CMD_ADD,   30'h1555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_READ,  30'h2AAA_AAAA, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_CLEAR, 30'h3FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'sh0000_0000, 1'b0, 7'd0, 1'b0}},
        '{CMD_READ,  30'h0000_0012, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 7'd0, 1'b0}},
        '{CMD_ADD,   30'h0000_0012, 32'h0000_0005, 1'b1, '{32'sh0000_0005, 1'b0, 7'd1, 1'b1}},
        '{CMD_ADD,   30'h0000_0010, 32'hFFFF_FFFD, 1'b0, '0},
        '{CMD_READ,  30'h0000_0013, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 7'd1, 1'b0}},
        '{CMD_ADD,   30'h3FFF_FFF0, 32'h1234_5678, 1'b0, '0}
    };

    function automatic void clear_map();
        int k;
        live_chunks = 0;
        for (k = 0; k < DEPTH; k++) entry_set[k] = 1'b0;
    endfunction

    function automatic t_pix_result pixel_map_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [PIXEL_BITS-1:0] pixel,
                                                   input logic signed [VALUE_W-1:0] inc);
        t_pix_result           r;
        int                    sh;
        int                    i;
        int                    k;
        int                    slot;
        int                    addr;
        bit                    hit;
        logic [PIXEL_BITS-1:0] tag;
        logic [PIXEL_BITS-1:0] off;
        longint                sum;
        r    = '0;
        sh   = (shift_now > MAX_CHUNK_SHIFT) ? MAX_CHUNK_SHIFT : int'(shift_now);
        tag  = pixel >> sh;
        off  = pixel & ((30'd1 << sh) - 30'd1);
        hit  = 1'b0;
        slot = 0;
        for (i = 0; i < live_chunks; i++) begin
            if (!hit && chunk_tag[i] == tag) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        case (cmd)
            CMD_ADD: begin
                if (!hit && live_chunks >= MAX_CHUNKS) begin
                    r.status = 1'b1;
                end else begin
                    if (!hit) begin
                        slot            = live_chunks;
                        chunk_tag[slot] = tag;
                        live_chunks++;
                        r.fresh = 1'b1;
                        for (k = 0; k < (1 << sh); k++) entry_set[(slot << sh) + k] = 1'b0;
                    end
                    addr = (slot << sh) | int'(off);
                    sum  = (entry_set[addr] ? longint'(count_mem[addr]) : 64'sd0)
                           + longint'(inc);
                    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                    count_mem[addr] = sum[31:0];
                    entry_set[addr] = 1'b1;
                    r.value         = sum[31:0];
                end
            end
            CMD_READ: begin
                if (hit) begin
                    addr = (slot << sh) | int'(off);
                    if (entry_set[addr]) r.value = count_mem[addr];
                end
            end
            CMD_CLEAR: clear_map();
            default: ;
        endcase
        r.active = COUNT_W'(live_chunks);
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [PIXEL_BITS-1:0] pixel,
                         input logic [VALUE_W-1:0] inc, input bit typed,
                         input t_pix_result typed_res);
        int          gap;
        t_pix_result res;
        gap = 0;
        while ($urandom_range(99) < snd_idle) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.pixel     <= pixel;
        in_ch.increment <= inc;
        do @(posedge clk); while (!in_ch.ready);
        res = pixel_map_step(cmd, pixel, inc);
        if (typed) res = typed_res;
        pixel_results_q = {pixel_results_q, res};
    endtask

    task automatic offer_random();
        logic [CMD_W-1:0]      cmd;
        logic [PIXEL_BITS-1:0] pix;
        logic [PIXEL_BITS-1:0] mask;
        logic [VALUE_W-1:0]    inc;
        int                    sh;
        int                    r;
        sh   = (shift_now > MAX_CHUNK_SHIFT) ? MAX_CHUNK_SHIFT : int'(shift_now);
        mask = (30'd1 << sh) - 30'd1;
        r    = $urandom_range(99);
        if (r < 55)      cmd = CMD_ADD;
        else if (r < 88) cmd = CMD_READ;
        else if (r < 90) cmd = CMD_CLEAR;
        else if (r < 94) cmd = CMD_SPARE;
        else             cmd = CMD_ADD;
        r = $urandom_range(99);
        if (r < 30 && recent_pix.size() > 0)
            pix = recent_pix[$urandom_range(recent_pix.size() - 1)];
        else if (r < 85)
            pix = (hot_pix[$urandom_range(HOT_N - 1)] & ~mask) | (30'($urandom) & mask);
        else
            pix = 30'($urandom);
        r = $urandom_range(99);
        if (r < 50) begin
            inc = 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
        end else if (r < 75) begin
            inc = $urandom;
        end else begin
            case ($urandom_range(3))
                0:       inc = 32'h7FFF_FFFF;
                1:       inc = 32'h8000_0000;
                2:       inc = 32'h7FFF_0000;
                default: inc = 32'h8001_0000;
            endcase
        end
        offer(cmd, pix, inc, 1'b0, '0);
        if (cmd == CMD_ADD) begin
            recent_pix = {recent_pix, pix};
            if (recent_pix.size() > 16) void'(recent_pix.pop_front());
        end
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] v);
        while (pixel_results_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        shift_now = v;
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    always @(posedge clk) begin
        t_pix_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pixel_results_q.size() == 0) begin
                note_mismatch("result with nothing expected");
            end else begin
                want = pixel_results_q.pop_front();
                if (out_ch.value !== want.value)
                    note_mismatch($sformatf("value got %h exp %h", out_ch.value, want.value));
                if (out_ch.status !== want.status)
                    note_mismatch($sformatf("status got %b exp %b", out_ch.status, want.status));
                if (out_ch.active_chunks !== want.active)
                    note_mismatch($sformatf("active_chunks got %0d exp %0d",
                                            out_ch.active_chunks, want.active));
                if (out_ch.new_chunk !== want.fresh)
                    note_mismatch($sformatf("new_chunk got %b exp %b",
                                            out_ch.new_chunk, want.fresh));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("sparse_chunked_pixel_accumulator_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        int n;
        int i;
        int ep_len;
        bit first;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_ADD;
        in_ch.pixel     = '0;
        in_ch.increment = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        snd_idle        = 14;
        rcv_stall       = 69;
        hold_left       = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        shift_now       = 4'd4;
        clear_map();
        for (i = 0; i < HOT_N; i++) hot_pix[i] = 30'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++)
            offer(dir_tab[i].cmd, dir_tab[i].pixel, dir_tab[i].inc,
                  dir_tab[i].typed, dir_tab[i].res);
        in_ch.valid <= 1'b0;

        for (p = 0; p < N_PHASES; p++) begin
            write_shift(PHASE_SHIFT[p]);
            case (p / 2)
                0: begin
                    snd_idle  = 14;
                    rcv_stall = 69;
                end
                1: begin
                    snd_idle  = 69;
                    rcv_stall = 14;
                end
                default: begin
                    snd_idle  = 0;
                    rcv_stall = 0;
                end
            endcase
            if (p == N_PHASES - 1) hold_left = HOLD_CYCLES;
            n     = 0;
            first = 1'b1;
            while (n < PHASE_ITEMS) begin
                if (!first) begin
                    offer(CMD_CLEAR, 30'($urandom), $urandom, 1'b0, '0);
                    n++;
                end
                first  = 1'b0;
                ep_len = $urandom_range(30, 160);
                for (i = 0; i < ep_len && n < PHASE_ITEMS; i++) begin
                    offer_random();
                    n++;
                end
            end
            in_ch.valid <= 1'b0;
        end

        while (pixel_results_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("sparse_chunked_pixel_accumulator_tb: PASS");
        else
            $display("sparse_chunked_pixel_accumulator_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/spca_pkg.sv
rtl/spca_if.sv
rtl/spca_ctrl.sv
rtl/spca_datapath.sv
rtl/sparse_chunked_pixel_accumulator.sv
test/sparse_chunked_pixel_accumulator_tb.sv
